/* hw/rtl/hsj_pkg.sv */
// Package for the Halton sub-pixel jitter unit: widths, register indexes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package hsj_pkg;

  localparam int IN_W       = 16;  // phase index field
  localparam int JIT_W      = 26;  // jitter fields
  localparam int N_W        = 17;  // index + 1
  localparam int SCALE_W    = 18;  // radical inverse numerator / scale (3^11 < 2^18)
  localparam int PC_W       = 16;
  localparam int RES_W      = 15;
  localparam int DEN_W      = SCALE_W + RES_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_HEIGHT  = 2'd2;

  localparam logic [PC_W-1:0]  PHASE_COUNT_RST = 16'd8;
  localparam logic [RES_W-1:0] RES_WIDTH_RST   = 15'd1920;
  localparam logic [RES_W-1:0] RES_HEIGHT_RST  = 15'd1080;

  // floor(m / 3) = (m * RECIP3) >> RECIP3_SHIFT, exact for m < 2^17
  localparam int              RECIP3_SHIFT = 17;
  localparam logic [N_W-1:0]  RECIP3       = 17'd43691;

  localparam logic [24:0] JIT_MAX_MAG = 25'h1000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_MULT,
    ST_DIVIDE,
    ST_FINAL
  } hsj_state_t;

  typedef struct packed {
    logic start;
    logic digit_step;
    logic mult;
    logic div_step;
    logic load_out;
  } hsj_cmd_t;

  typedef struct packed {
    logic oor;
    logic digits_done;
  } hsj_sts_t;

endpackage

/* hw/rtl/hsj_if.sv */
// Channel interfaces of the Halton sub-pixel jitter unit: valid/ready plus payload.
// Depends on hsj_pkg.
interface hsj_in_if;
  logic                       valid;
  logic                       ready;
  logic [hsj_pkg::IN_W-1:0]   phase_index;

  modport source (output valid, output phase_index, input ready);
  modport sink   (input valid, input phase_index, output ready);
endinterface

interface hsj_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [hsj_pkg::JIT_W-1:0]  jitter_x;
  logic signed [hsj_pkg::JIT_W-1:0]  jitter_y;
  logic                              last_phase;
  logic                              out_of_range;

  modport source (output valid, output jitter_x, output jitter_y, output last_phase,
                  output out_of_range, input ready);
  modport sink   (input valid, input jitter_x, input jitter_y, input last_phase,
                  input out_of_range, output ready);
endinterface

/* hw/rtl/hsj_ctrl.sv */
// Controller FSM of the Halton sub-pixel jitter unit: sequences digit extraction,
// denominator multiply, fraction division and result load. Depends on hsj_pkg.
module hsj_ctrl #(
  parameter int FRAC_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  hsj_pkg::hsj_sts_t sts,
  output hsj_pkg::hsj_cmd_t cmd
);

  localparam int CNT_W = $clog2(FRAC_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS - 1);

  hsj_pkg::hsj_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    div_cnt_r, div_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hsj_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = hsj_pkg::ST_DIGIT;
      end
      hsj_pkg::ST_DIGIT: begin
        if (sts.oor) state_nxt = hsj_pkg::ST_FINAL;
        else if (sts.digits_done) state_nxt = hsj_pkg::ST_MULT;
      end
      hsj_pkg::ST_MULT: begin
        state_nxt = hsj_pkg::ST_DIVIDE;
      end
      hsj_pkg::ST_DIVIDE: begin
        if (div_cnt_r == CNT_LAST) state_nxt = hsj_pkg::ST_FINAL;
      end
      hsj_pkg::ST_FINAL: begin
        if (!out_valid_r || out_ready) state_nxt = hsj_pkg::ST_IDLE;
      end
      default: state_nxt = hsj_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      hsj_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      hsj_pkg::ST_DIGIT: begin
        cmd.digit_step = !sts.oor && !sts.digits_done;
      end
      hsj_pkg::ST_MULT: begin
        cmd.mult = 1'b1;
      end
      hsj_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      hsj_pkg::ST_FINAL: begin
        cmd.load_out = !out_valid_r || out_ready;
      end
      default: ;
    endcase
  end

  always_comb begin
    div_cnt_nxt = div_cnt_r;
    if (cmd.mult) div_cnt_nxt = '0;
    else if (cmd.div_step) div_cnt_nxt = div_cnt_r + CNT_W'(1);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hsj_pkg::ST_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register loaded while previous result pending");

  a_start_to_digit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (state_r == hsj_pkg::ST_DIGIT))
    else $error("accepted transaction did not enter digit phase");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result loaded without raising valid");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hsj_pkg::ST_DIVIDE) && (div_cnt_r == CNT_LAST) |=>
      (state_r == hsj_pkg::ST_FINAL))
    else $error("division did not end after FRAC_BITS steps");

endmodule

/* hw/rtl/hsj_datapath.sv */
// Datapath of the Halton sub-pixel jitter unit: config registers, base-2/base-3
// digit reversal, denominator multiply, restoring division, result register.
// Depends on hsj_pkg.
module hsj_datapath #(
  parameter int FRAC_BITS  = 24,
  parameter int INDEX_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [hsj_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hsj_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [hsj_pkg::IN_W-1:0]            in_phase_index,
  input  hsj_pkg::hsj_cmd_t                   cmd,
  output hsj_pkg::hsj_sts_t                   sts,
  output logic signed [hsj_pkg::JIT_W-1:0]    out_jitter_x,
  output logic signed [hsj_pkg::JIT_W-1:0]    out_jitter_y,
  output logic                                out_last_phase,
  output logic                                out_out_of_range
);

  localparam int N_W     = hsj_pkg::N_W;
  localparam int SCALE_W = hsj_pkg::SCALE_W;
  localparam int DEN_W   = hsj_pkg::DEN_W;
  localparam int JIT_W   = hsj_pkg::JIT_W;
  localparam logic [hsj_pkg::IN_W-1:0] IDX_MASK = (INDEX_BITS >= hsj_pkg::IN_W) ?
      {hsj_pkg::IN_W{1'b1}} : hsj_pkg::IN_W'((33'd1 << INDEX_BITS) - 33'd1);

  logic [hsj_pkg::PC_W-1:0]  phase_count_r;
  logic [hsj_pkg::RES_W-1:0] res_width_r, res_height_r;

  logic [N_W-1:0]     n_r, m2_r, m3_r;
  logic               oor_r;
  logic [SCALE_W-1:0] rev2_r, scale2_r, rev3_r, scale3_r;
  logic               neg2_r, neg3_r;
  logic [DEN_W-1:0]   den2_r, den3_r, rem2_r, rem3_r;
  logic [FRAC_BITS-1:0] q2_r, q3_r;

  logic signed [JIT_W-1:0] jx_r, jy_r;
  logic                    last_r, oor_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_count_r <= hsj_pkg::PHASE_COUNT_RST;
      res_width_r   <= hsj_pkg::RES_WIDTH_RST;
      res_height_r  <= hsj_pkg::RES_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hsj_pkg::CFG_PHASE_COUNT: phase_count_r <= cfg_data;
        hsj_pkg::CFG_RES_WIDTH:   res_width_r   <= cfg_data[hsj_pkg::RES_W-1:0];
        hsj_pkg::CFG_RES_HEIGHT:  res_height_r  <= cfg_data[hsj_pkg::RES_W-1:0];
        default: ;
      endcase
    end
  end

  // start
  logic [hsj_pkg::IN_W-1:0] idx_m;
  assign idx_m = in_phase_index & IDX_MASK;

  // base-3 digit by reciprocal multiply
  logic [2*N_W-1:0] prod3;
  logic [N_W-1:0]   m3_div;
  logic [1:0]       d3;
  assign prod3  = (2*N_W)'(m3_r) * (2*N_W)'(hsj_pkg::RECIP3);
  assign m3_div = prod3[2*N_W-1:hsj_pkg::RECIP3_SHIFT];
  assign d3     = 2'(m3_r - (m3_div << 1) - m3_div);

  // 2h - 1 numerators
  logic [SCALE_W:0] two_rev2, two_rev3;
  assign two_rev2 = {rev2_r, 1'b0};
  assign two_rev3 = {rev3_r, 1'b0};

  // restoring division steps
  logic [DEN_W:0] sh2, sh3;
  logic           ge2, ge3;
  assign sh2 = {rem2_r, 1'b0};
  assign sh3 = {rem3_r, 1'b0};
  assign ge2 = sh2 >= {1'b0, den2_r};
  assign ge3 = sh3 >= {1'b0, den3_r};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      oor_r    <= {1'b0, idx_m} >= {1'b0, phase_count_r};
      n_r      <= N_W'(idx_m) + N_W'(1);
      m2_r     <= N_W'(idx_m) + N_W'(1);
      m3_r     <= N_W'(idx_m) + N_W'(1);
      rev2_r   <= '0;
      rev3_r   <= '0;
      scale2_r <= SCALE_W'(1);
      scale3_r <= SCALE_W'(1);
    end else if (cmd.digit_step) begin
      if (m2_r != '0) begin
        m2_r     <= m2_r >> 1;
        rev2_r   <= {rev2_r[SCALE_W-2:0], m2_r[0]};
        scale2_r <= scale2_r << 1;
      end
      if (m3_r != '0) begin
        m3_r     <= m3_div;
        rev3_r   <= SCALE_W'((rev3_r << 1) + rev3_r + SCALE_W'(d3));
        scale3_r <= SCALE_W'((scale3_r << 1) + scale3_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      neg2_r <= two_rev2 < {1'b0, scale2_r};
      neg3_r <= two_rev3 < {1'b0, scale3_r};
      rem2_r <= (two_rev2 < {1'b0, scale2_r}) ?
                DEN_W'({1'b0, scale2_r} - two_rev2) : DEN_W'(two_rev2 - {1'b0, scale2_r});
      rem3_r <= (two_rev3 < {1'b0, scale3_r}) ?
                DEN_W'({1'b0, scale3_r} - two_rev3) : DEN_W'(two_rev3 - {1'b0, scale3_r});
      den2_r <= DEN_W'(scale2_r) * DEN_W'(res_width_r);
      den3_r <= DEN_W'(scale3_r) * DEN_W'(res_height_r);
      q2_r   <= '0;
      q3_r   <= '0;
    end else if (cmd.div_step) begin
      rem2_r <= ge2 ? DEN_W'(sh2 - {1'b0, den2_r}) : sh2[DEN_W-1:0];
      rem3_r <= ge3 ? DEN_W'(sh3 - {1'b0, den3_r}) : sh3[DEN_W-1:0];
      q2_r   <= {q2_r[FRAC_BITS-2:0], ge2};
      q3_r   <= {q3_r[FRAC_BITS-2:0], ge3};
    end
  end

  function automatic logic signed [JIT_W-1:0] fin(input logic [FRAC_BITS-1:0] q,
                                                  input logic neg);
    logic [32:0] q_ext;
    logic [24:0] mag;
    q_ext = 33'(q);
    mag   = (q_ext > 33'(hsj_pkg::JIT_MAX_MAG)) ? hsj_pkg::JIT_MAX_MAG : q_ext[24:0];
    return neg ? -JIT_W'(mag) : JIT_W'(mag);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (oor_r) begin
        jx_r      <= '0;
        jy_r      <= '0;
        last_r    <= 1'b0;
        oor_out_r <= 1'b1;
      end else begin
        jx_r      <= (res_width_r == '0) ? '0 : fin(q2_r, neg2_r);
        jy_r      <= (res_height_r == '0) ? '0 : fin(q3_r, neg3_r);
        last_r    <= n_r == N_W'(phase_count_r);
        oor_out_r <= 1'b0;
      end
    end
  end

  assign sts.oor         = oor_r;
  assign sts.digits_done = (m2_r == '0) && (m3_r == '0);

  assign out_jitter_x     = jx_r;
  assign out_jitter_y     = jy_r;
  assign out_last_phase   = last_r;
  assign out_out_of_range = oor_out_r;

  a_mult_after_digits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mult |-> ((m2_r == '0) && (m3_r == '0) && !oor_r))
    else $error("denominator formed before digit reversal finished");

endmodule

/* hw/rtl/halton_subpixel_jitter_unit.sv */
// Halton sub-pixel jitter unit, top level: channels, config port, controller and datapath.
// Depends on hsj_pkg, hsj_if, hsj_ctrl, hsj_datapath.
//
// For each phase index transaction the unit returns one jitter pair: x from the base-2
// and y from the base-3 radical inverse of index+1, mapped to 2h-1 and divided by the
// render width/height, as signed fixed point with FRAC_BITS fraction bits, truncated.
// One item is processed at a time. An in-range index steps through the radical-inverse
// loop at one digit per cycle, then the denominator multiply, then the restoring divider
// at one quotient bit per cycle. An out-of-range index skips the digit loop, multiply
// and division. The result sits in an output register, so the next transaction is
// accepted while it waits.
module halton_subpixel_jitter_unit #(
  parameter int FRAC_BITS  = 24,
  parameter int INDEX_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  hsj_in_if.sink                           in_chan,
  hsj_out_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [hsj_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hsj_pkg::CFG_DATA_W-1:0]   cfg_data
);

  hsj_pkg::hsj_cmd_t cmd;
  hsj_pkg::hsj_sts_t sts;

  hsj_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hsj_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_phase_index   (in_chan.phase_index),
    .cmd              (cmd),
    .sts              (sts),
    .out_jitter_x     (out_chan.jitter_x),
    .out_jitter_y     (out_chan.jitter_y),
    .out_last_phase   (out_chan.last_phase),
    .out_out_of_range (out_chan.out_of_range)
  );

endmodule
